// ===== rtl/sddf_pkg.sv =====
`default_nettype none
package sddf_pkg;

  localparam int unsigned NUM_POS   = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CODE_W    = 4;
  // 99999999 < 2**27, so every displayable magnitude fits here
  localparam int unsigned MAG_W     = 27;
  localparam int unsigned CNT_W     = $clog2(MAG_W);

  localparam logic signed [VALUE_W-1:0] POS_LIMIT = 32'sd99999999;
  localparam logic signed [VALUE_W-1:0] NEG_LIMIT = -32'sd9999999;

  localparam logic [CODE_W-1:0] CODE_ZERO  = 4'd0;
  localparam logic [CODE_W-1:0] CODE_DASH  = 4'd10;
  localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sddf_if.sv =====
`default_nettype none
interface sddf_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [sddf_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sddf_out_if;
  logic                 valid;
  logic                 ready;
  sddf_pkg::code_t      digit_code_0;
  sddf_pkg::code_t      digit_code_1;
  sddf_pkg::code_t      digit_code_2;
  sddf_pkg::code_t      digit_code_3;
  sddf_pkg::code_t      digit_code_4;
  sddf_pkg::code_t      digit_code_5;
  sddf_pkg::code_t      digit_code_6;
  sddf_pkg::code_t      digit_code_7;
  logic                 overflow;

  modport source (output valid, output digit_code_0, output digit_code_1,
                  output digit_code_2, output digit_code_3, output digit_code_4,
                  output digit_code_5, output digit_code_6, output digit_code_7,
                  output overflow, input ready);
  modport sink   (input valid, input digit_code_0, input digit_code_1,
                  input digit_code_2, input digit_code_3, input digit_code_4,
                  input digit_code_5, input digit_code_6, input digit_code_7,
                  input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/sddf_bcd_cell.sv =====
`default_nettype none
// One BCD digit of a shift-add-3 chain.
module sddf_bcd_cell (
  input  wire                   clk,
  input  sddf_pkg::cell_ctrl_t  ctrl,
  input  wire                   bit_in,
  output logic                  bit_out,
  output sddf_pkg::code_t       digit
);

  sddf_pkg::code_t adj;

  // add 3 before the shift when the digit would pass nine
  always_comb begin
    adj     = (digit >= 4'd5) ? sddf_pkg::code_t'(digit + 4'd3) : digit;
    bit_out = adj[3];
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= sddf_pkg::CODE_ZERO;
    end else if (ctrl.shift) begin
      digit <= {adj[2:0], bit_in};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/signed_decimal_digit_formatter.sv =====
`default_nettype none
// Signed decimal digit formatter for an eight-position Code B display.
//
// in_ch  : one signed 32-bit value per transaction (valid/ready).
// out_ch : eight 4-bit position codes plus an overflow flag per transaction.
//          Codes: 0-9 digit, 10 dash, 15 blank; position 0 is least significant.
//
// The magnitude is shifted, one bit per cycle, into a row of eight BCD cells
// (shift-add-3), one shift per bit of the 27-bit magnitude. The FINISH state
// then loads the result into the output register; out_ch.valid rises and
// in_ch.ready returns with it, so a new value is not taken until the last
// conversion has been loaded. An out-of-range value skips the cell row: it
// goes straight from IDLE to FINISH, and its result is loaded with overflow
// set and all codes zero.
//
// in_ch.ready is high only while the converter is free. The result sits in an
// output register, so a new value is taken while an earlier result still waits.
// When the receiver stalls, the finished conversion holds until that register
// frees, and in_ch.ready stays low in the meantime.
// Reset (rst, synchronous) empties the output register and returns to idle.
module signed_decimal_digit_formatter (
  input  wire        clk,
  input  wire        rst,
  sddf_in_if.sink    in_ch,
  sddf_out_if.source out_ch
);

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    FINISH
  } state_t;

  state_t                              state;
  logic [sddf_pkg::MAG_W-1:0]          mag;
  logic [sddf_pkg::CNT_W-1:0]          cnt;
  logic                                neg;
  logic                                ovf;

  sddf_pkg::code_t                     out_code [sddf_pkg::NUM_POS];
  logic                                out_ovf;
  logic                                out_valid;

  sddf_pkg::cell_ctrl_t                cell_ctrl;
  logic [sddf_pkg::NUM_POS:0]          chain;
  sddf_pkg::code_t                     digit [sddf_pkg::NUM_POS];

  logic                                in_take;
  logic                                out_free;
  logic                                out_load;
  logic                                in_ovf;
  logic [sddf_pkg::VALUE_W-1:0]        in_abs;

  logic [sddf_pkg::NUM_POS-1:0]        sig;
  sddf_pkg::code_t                     code_next [sddf_pkg::NUM_POS];

  assign in_ch.ready = (state == IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  // move the finished conversion into the output register
  assign out_load    = (state == FINISH) && out_free;

  assign in_ovf = (in_ch.value > sddf_pkg::POS_LIMIT) ||
                  (in_ch.value < sddf_pkg::NEG_LIMIT);
  assign in_abs = in_ch.value[sddf_pkg::VALUE_W-1] ?
                  sddf_pkg::VALUE_W'(-in_ch.value) : in_ch.value;

  assign cell_ctrl.clear = in_take;
  assign cell_ctrl.shift = (state == CONV);

  // feed the magnitude MSB first into the least significant cell
  assign chain[0] = mag[sddf_pkg::MAG_W-1];

  for (genvar i = 0; i < sddf_pkg::NUM_POS; i++) begin : g_cell
    sddf_bcd_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .bit_in  (chain[i]),
      .bit_out (chain[i+1]),
      .digit   (digit[i])
    );
  end

  // Blank leading zeros; place the dash just above the top significant digit; on overflow every code is zero.
  always_comb begin
    for (int i = sddf_pkg::NUM_POS - 1; i >= 0; i--) begin
      if (i == sddf_pkg::NUM_POS - 1) begin
        sig[i] = (digit[i] != sddf_pkg::CODE_ZERO);
      end else begin
        sig[i] = sig[i+1] || (digit[i] != sddf_pkg::CODE_ZERO);
      end
    end
    for (int i = 0; i < sddf_pkg::NUM_POS; i++) begin
      if (ovf) begin
        code_next[i] = sddf_pkg::CODE_ZERO;
      end else if (sig[i]) begin
        code_next[i] = digit[i];
      end else if (neg && (i == 0 || sig[(i == 0) ? 0 : i-1])) begin
        code_next[i] = sddf_pkg::CODE_DASH;
      end else begin
        code_next[i] = sddf_pkg::CODE_BLANK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_take) begin
            mag   <= in_abs[sddf_pkg::MAG_W-1:0];
            neg   <= in_ch.value[sddf_pkg::VALUE_W-1];
            ovf   <= in_ovf;
            cnt   <= '0;
            state <= in_ovf ? FINISH : CONV;
          end
        end
        CONV: begin
          mag <= {mag[sddf_pkg::MAG_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == sddf_pkg::CNT_W'(sddf_pkg::MAG_W - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          // hold the converted digits until the output register frees
          if (out_load) begin
            out_code <= code_next;
            out_ovf  <= ovf;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.overflow     = out_ovf;
  assign out_ch.digit_code_0 = out_code[0];
  assign out_ch.digit_code_1 = out_code[1];
  assign out_ch.digit_code_2 = out_code[2];
  assign out_ch.digit_code_3 = out_code[3];
  assign out_ch.digit_code_4 = out_code[4];
  assign out_ch.digit_code_5 = out_code[5];
  assign out_ch.digit_code_6 = out_code[6];
  assign out_ch.digit_code_7 = out_code[7];

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !in_ch.ready)
    else $error("converter took a value while busy");

  a_ovf_codes_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ovf) |->
      (out_code[0] == sddf_pkg::CODE_ZERO && out_code[7] == sddf_pkg::CODE_ZERO))
    else $error("overflow result with nonzero codes");

  a_no_dash_bottom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_code[0] != sddf_pkg::CODE_DASH))
    else $error("dash in least significant position");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == CONV) |-> (cnt < sddf_pkg::CNT_W'(sddf_pkg::MAG_W)))
    else $error("shift count ran past magnitude width");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid)
    else $error("stalled result dropped");

endmodule
`default_nettype wire
